@@ rtl/ssd_pkg.sv @@
`timescale 1ns / 1ps
package ssd_pkg;

  localparam int DIGIT_COUNT  = 4;
  // A frame holds at most 32 bits, so the chain is driven with one to four digits.
  localparam int FRAME_DIGITS = (DIGIT_COUNT > 4) ? 4 : ((DIGIT_COUNT < 1) ? 1 : DIGIT_COUNT);
  localparam int FRAME_W      = 32;
  localparam int POS_W        = 5;
  localparam int VALUE_W      = 14;
  localparam int ACT_W        = 2;
  localparam int CNT_W        = (FRAME_DIGITS > 1) ? $clog2(FRAME_DIGITS) : 1;

  localparam logic [ACT_W-1:0] ACT_SHOW  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DASH  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

  localparam logic [7:0] DASH_CODE = 8'h40;

  localparam logic [POS_W-1:0] LAST_POS_FULL = POS_W'(8 * FRAME_DIGITS - 1);
  localparam logic [POS_W-1:0] LAST_POS_DASH = POS_W'(7);

  // Queue entry: a left-aligned frame, sent from bit 31 down, and its final position.
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [POS_W-1:0]   last_pos;
  } ssd_cmd_t;

  function automatic logic [7:0] digit_to_segments(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/ssd_front.sv @@
`timescale 1ns / 1ps
module ssd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ssd_pkg::ACT_W-1:0]   in_action,
  input  logic [ssd_pkg::VALUE_W-1:0] in_value,
  output logic                        push_valid,
  input  logic                        push_ready,
  output ssd_pkg::ssd_cmd_t           push_cmd
);
  import ssd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  // 52429 / 2^19 is close enough to 1/10 for every 14-bit value.
  localparam logic [29:0] RECIP = 30'd52429;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_W-1:0] rem_r, rem_nxt;
  logic [ACT_W-1:0]   act_r, act_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;

  logic [29:0]        prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] quot_x10;
  logic [3:0]         digit;
  logic [7:0]         code;

  assign prod     = 30'(rem_r) * RECIP;
  assign quot     = VALUE_W'(prod[29:19]);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign digit    = 4'(rem_r - quot_x10);
  // A higher digit whose remaining quotient is already zero is a leading zero.
  assign code     = (cnt_r != '0 && rem_r == '0) ? 8'h00 : digit_to_segments(digit);

  assign in_tready  = (state_r == ST_IDLE);
  assign push_valid = (state_r == ST_PUSH);

  always_comb begin
    case (act_r)
      ACT_SHOW: begin
        push_cmd.frame    = frame_r;
        push_cmd.last_pos = LAST_POS_FULL;
      end
      ACT_DASH: begin
        push_cmd.frame    = {DASH_CODE, {(FRAME_W-8){1'b0}}};
        push_cmd.last_pos = LAST_POS_DASH;
      end
      default: begin
        push_cmd.frame    = '0;
        push_cmd.last_pos = LAST_POS_FULL;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    act_nxt   = act_r;
    frame_nxt = frame_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          rem_nxt   = in_value;
          act_nxt   = in_action;
          cnt_nxt   = '0;
          frame_nxt = '0;
          state_nxt = (in_action == ACT_NONE) ? ST_IDLE : ST_CONV;
        end
      end
      ST_CONV: begin
        frame_nxt = {code, frame_r[FRAME_W-1:8]};
        rem_nxt   = quot;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAME_DIGITS - 1)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    act_r   <= act_nxt;
    frame_r <= frame_nxt;
  end

endmodule

@@ rtl/ssd_queue.sv @@
`timescale 1ns / 1ps
module ssd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  ssd_pkg::ssd_cmd_t push_cmd,
  output logic              pop_valid,
  input  logic              pop_ready,
  output ssd_pkg::ssd_cmd_t pop_cmd
);
  import ssd_pkg::*;

  ssd_cmd_t   entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/ssd_back.sv @@
`timescale 1ns / 1ps
module ssd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pop_valid,
  output logic                      pop_ready,
  input  ssd_pkg::ssd_cmd_t         pop_cmd,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic                      out_serial_bit,
  output logic [ssd_pkg::POS_W-1:0] out_bit_position,
  output logic                      out_last_and_latch
);
  import ssd_pkg::*;

  logic               active_r;
  logic [FRAME_W-1:0] shreg_r;
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   last_pos_r;
  logic               valid_r;
  logic               bit_r;
  logic [POS_W-1:0]   opos_r;
  logic               olast_r;

  logic adv;
  logic at_last;

  assign adv     = !valid_r || out_tready;
  assign at_last = (pos_r == last_pos_r);
  // The next frame loads while the final bit of the current one goes out.
  assign pop_ready = adv && (!active_r || at_last);

  assign out_tvalid         = valid_r;
  assign out_serial_bit     = bit_r;
  assign out_bit_position   = opos_r;
  assign out_last_and_latch = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      valid_r  <= 1'b0;
    end else if (adv) begin
      valid_r <= active_r;
      if (pop_valid && pop_ready) begin
        active_r <= 1'b1;
      end else if (active_r && at_last) begin
        active_r <= 1'b0;
      end
    end
    if (adv) begin
      if (active_r) begin
        bit_r   <= shreg_r[FRAME_W-1];
        opos_r  <= pos_r;
        olast_r <= at_last;
        shreg_r <= shreg_r << 1;
        pos_r   <= pos_r + 1'b1;
      end
      if (pop_valid && pop_ready) begin
        shreg_r    <= pop_cmd.frame;
        pos_r      <= '0;
        last_pos_r <= pop_cmd.last_pos;
      end
    end
  end

endmodule

@@ rtl/seven_segment_serial_display_driver_core.sv @@
`timescale 1ns / 1ps
// Throughput: one bit per cycle unless out_tready stalls, set by the single-bit output shifter;
// a show or clear command sends 8 * FRAME_DIGITS bits (32 with four digits), a dash command 8 bits.
// The digit front end runs ahead through a two-entry queue. Reset (rst_n low, synchronous)
// empties the queue and the output stage.
module seven_segment_serial_display_driver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [13:0] value, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] serial_bit, [5:1] bit_position, [7:6] zero
  output logic        out_tlast
);
  import ssd_pkg::*;

  logic       push_valid, push_ready;
  ssd_cmd_t   push_cmd;
  logic       pop_valid, pop_ready;
  ssd_cmd_t   pop_cmd;
  logic       serial_bit;
  logic [POS_W-1:0] bit_position;

  ssd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_tuser),
    .in_value   (in_tdata[VALUE_W-1:0]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  ssd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  ssd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_ready          (pop_ready),
    .pop_cmd            (pop_cmd),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_serial_bit     (serial_bit),
    .out_bit_position   (bit_position),
    .out_last_and_latch (out_tlast)
  );

  assign out_tdata = {2'b00, bit_position, serial_bit};

  // A frame ends only at the last bit of a dash or of a full frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (out_tdata[5:1] == LAST_POS_DASH || out_tdata[5:1] == LAST_POS_FULL))
    else $error("frame ended at an unexpected bit position");

  // Within a frame the bits follow without gaps.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && out_tdata[5:1] == POS_W'($past(out_tdata[5:1]) + 5'd1)))
    else $error("bit position did not advance within a frame");

  // After the latch bit the next transfer, if any, starts a new frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid || out_tdata[5:1] == '0))
    else $error("new frame did not start at bit zero");

endmodule
